/* rtl/bcrm_pkg.sv */
// Shared types, constants and helpers for the bit-plane context / run-length modeler.
package bcrm_pkg;

   localparam int COEF_BITS = 16;
   localparam int PLANE_W   = 4;
   localparam int MASK_W    = 15;
   localparam int ALU_W     = 19;
   localparam int CTX_W     = 6;
   localparam int SCTX_W    = 4;
   localparam int BAND_PIXELS_DEF = 65536;

   localparam logic [2:0] CLS_SIG    = 3'd0;
   localparam logic [2:0] CLS_SIGN   = 3'd1;
   localparam logic [2:0] CLS_RZERO  = 3'd2;
   localparam logic [2:0] CLS_RUNARY = 3'd3;
   localparam logic [2:0] CLS_RBITS  = 3'd4;

   localparam logic CSR_BIT_PLANE = 1'b0;
   localparam logic CSR_NEXT_MASK = 1'b1;

   localparam logic FUNC_COEF  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [SCTX_W-1:0] SCTX_N_NEG = 4'd1;
   localparam logic [SCTX_W-1:0] SCTX_N_POS = 4'd2;
   localparam logic [SCTX_W-1:0] SCTX_W_NEG = 4'd3;
   localparam logic [SCTX_W-1:0] SCTX_W_POS = 4'd6;

   localparam logic [3:0] VAL_CTX_MAX = 4'd15;

   typedef struct packed {
      logic                        func;
      logic signed [COEF_BITS-1:0] coefficient;
      logic signed [COEF_BITS-1:0] north_coef;
      logic signed [COEF_BITS-1:0] west_coef;
      logic signed [COEF_BITS-1:0] parent_coef;
      logic                        first_row;
      logic                        first_col;
   } req_type;

   typedef struct packed {
      logic             coded_bit;
      logic [2:0]       model_class;
      logic [CTX_W-1:0] context_index;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic       busy;
      logic       coded_bit;
      logic [2:0] model_class;
      logic       final_beat;
   } run_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACC1,
      ST_ACC2,
      ST_CMPN,
      ST_CMPW,
      ST_SIG,
      ST_SIGN
   } state_type;

   typedef enum logic [1:0] {
      RUN_IDLE,
      RUN_ZERO,
      RUN_UNARY,
      RUN_BITS
   } run_phase_type;

   function automatic logic [COEF_BITS-1:0] coef_mag(input logic [COEF_BITS-1:0] v);
      coef_mag = v[COEF_BITS-1] ? (~v + COEF_BITS'(1)) : v;
   endfunction

endpackage

/* rtl/bcrm_alu.sv */
// Shared add/subtract unit for the context sum and the shape compares.
module bcrm_alu (
   input  logic [bcrm_pkg::ALU_W-1:0] a,
   input  logic [bcrm_pkg::ALU_W-1:0] b,
   input  logic                       sub,
   output logic [bcrm_pkg::ALU_W-1:0] res
);
   import bcrm_pkg::*;

   logic [ALU_W-1:0] b_op;

   assign b_op = sub ? ~b : b;
   assign res  = a + b_op + ALU_W'(sub);

endmodule

/* rtl/bcrm_run.sv */
// Zero-run serializer: zero flag, unary bit count, then remainder bits, one beat per step.
module bcrm_run #(
   parameter int RUN_W = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RUN_W-1:0]      start_len,
   input  logic                  adv,
   output bcrm_pkg::run_beat_type beat
);
   import bcrm_pkg::*;

   localparam int CNT_W = (RUN_W > 1) ? $clog2(RUN_W) : 1;

   run_phase_type    phase_ff, phase_in;
   logic [RUN_W-1:0] len_ff, len_in;
   logic [RUN_W-1:0] tmp_ff, tmp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_idx;
   logic             tmp_gt1;
   logic             len_zero;

   assign cnt_idx  = cnt_ff - CNT_W'(1);
   assign tmp_gt1  = tmp_ff > RUN_W'(1);
   assign len_zero = len_ff == '0;

   always_comb begin
      beat = '0;
      case (phase_ff)
         RUN_ZERO: begin
            beat.busy        = 1'b1;
            beat.coded_bit   = len_zero;
            beat.model_class = CLS_RZERO;
            beat.final_beat  = len_zero;
         end
         RUN_UNARY: begin
            beat.busy        = 1'b1;
            beat.coded_bit   = !tmp_gt1;
            beat.model_class = CLS_RUNARY;
            beat.final_beat  = !tmp_gt1 && (cnt_ff == '0);
         end
         RUN_BITS: begin
            beat.busy        = 1'b1;
            beat.coded_bit   = len_ff[cnt_idx];
            beat.model_class = CLS_RBITS;
            beat.final_beat  = cnt_ff == CNT_W'(1);
         end
         default: begin
            beat = '0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      tmp_in   = tmp_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         phase_in = RUN_ZERO;
         len_in   = start_len;
      end else if (adv) begin
         case (phase_ff)
            RUN_ZERO: begin
               tmp_in   = len_ff;
               cnt_in   = '0;
               phase_in = len_zero ? RUN_IDLE : RUN_UNARY;
            end
            RUN_UNARY: begin
               if (tmp_gt1) begin
                  tmp_in = tmp_ff >> 1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  phase_in = (cnt_ff == '0) ? RUN_IDLE : RUN_BITS;
               end
            end
            RUN_BITS: begin
               cnt_in = cnt_idx;
               if (cnt_ff == CNT_W'(1)) begin
                  phase_in = RUN_IDLE;
               end
            end
            default: begin
               phase_in = RUN_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RUN_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      len_ff <= len_in;
      tmp_ff <= tmp_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* rtl/bitplane_context_runlength_modeler_top.sv */
// Top level of the bit-plane context modeler with zero run-length coding.
// Input channel req_*: one beat per coefficient (func 0) or end-of-band flush (func 1).
// Result channel rsp_*: one binary decision per beat with model class, context and a
// last flag on the final decision of each input beat; an input may give no beats.
// csr_*: bit_plane (index 0) and next_mask (index 1), to be written only while idle by
// the user; the block does not enforce it. An input beat is taken only in the idle
// state; req_ready is low while it is worked on. A zero that extends an open run gives
// nothing. A coded coefficient goes through the states EVAL, ACC1, ACC2, CMPN, CMPW
// and SIG (then SIGN for a sign beat) before the next accept; its significance beat is
// registered from SIG. Five passes through the shared adder build the neighborhood sum
// (three adds) and the two shape compares. A run closed by it (1 beat for an empty run,
// else 2 + 2*floor(log2(n)) beats for n zeros still owed) drains one beat per cycle
// while the receiver takes them, alongside the adder passes; the significance beat
// waits for the last of them. A flush of a run waits in SIG until its beats have
// drained; a flush with no run open gives nothing. The one result register decouples
// the channels; a stalled receiver holds the current beat and the block waits. Reset
// clears the state, run counter, flush flag, CSRs and rsp_valid, so no run is open.
module bitplane_context_runlength_modeler_top #(
   parameter int BAND_PIXELS = bcrm_pkg::BAND_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bcrm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bcrm_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bcrm_pkg::MASK_W-1:0]     csr_wdata
);
   import bcrm_pkg::*;

   localparam int RUN_W = $clog2(BAND_PIXELS + 1);

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [ALU_W-1:0]       acc_ff, acc_in;
   logic                   gtn_ff, gtn_in;
   logic                   gtw_ff, gtw_in;
   logic                   flush_ff, flush_in;
   logic [RUN_W-1:0]       zero_run_ff, zero_run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [PLANE_W-1:0]     bit_plane_ff;
   logic [MASK_W-1:0]      next_mask_ff;

   logic [COEF_BITS-1:0]   mask16;
   logic [COEF_BITS-1:0]   done_mask;
   logic [COEF_BITS-1:0]   mag;
   logic [COEF_BITS-1:0]   vd;
   logic [COEF_BITS-1:0]   par_m;
   logic [COEF_BITS-1:0]   north_m;
   logic [COEF_BITS-1:0]   west_m;
   logic [COEF_BITS-1:0]   nn;
   logic [COEF_BITS-1:0]   w;
   logic                   plane_bit;
   logic                   sign_needed;
   logic                   run_open;
   logic [SCTX_W-1:0]      sctx;
   logic [3:0]             val_ctx;
   logic                   out_free;

   logic [ALU_W-1:0]       alu_a;
   logic [ALU_W-1:0]       alu_b;
   logic                   alu_sub;
   logic [ALU_W-1:0]       alu_res;

   logic                   run_start;
   logic                   run_adv;
   logic [RUN_W-1:0]       run_len;
   run_beat_type           run_beat;

   bcrm_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu_res)
   );

   bcrm_run #(
      .RUN_W (RUN_W)
   ) u_run (
      .clock     (clock),
      .reset     (reset),
      .start     (run_start),
      .start_len (run_len),
      .adv       (run_adv),
      .beat      (run_beat)
   );

   assign mask16      = COEF_BITS'(next_mask_ff);
   assign done_mask   = mask16 ^ (COEF_BITS'(1) << bit_plane_ff);
   assign mag         = coef_mag(item_ff.coefficient);
   assign vd          = mag & done_mask;
   assign par_m       = coef_mag(item_ff.parent_coef) & mask16;
   assign north_m     = coef_mag(item_ff.north_coef) & mask16;
   assign west_m      = coef_mag(item_ff.west_coef) & mask16;
   assign nn          = item_ff.first_row ? vd : north_m;
   assign w           = item_ff.first_col ? vd : west_m;
   assign plane_bit   = mag[bit_plane_ff];
   assign sign_needed = plane_bit && (vd == '0);
   assign run_open    = zero_run_ff != '0;
   assign run_len     = zero_run_ff - RUN_W'(1);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign val_ctx     = (|acc_ff[ALU_W-1:6]) ? VAL_CTX_MAX : acc_ff[5:2];

   always_comb begin
      sctx = '0;
      if (!item_ff.first_row && (north_m != '0)) begin
         sctx = item_ff.north_coef[COEF_BITS-1] ? SCTX_N_NEG : SCTX_N_POS;
      end
      if (!item_ff.first_col && (west_m != '0)) begin
         sctx = sctx + (item_ff.west_coef[COEF_BITS-1] ? SCTX_W_NEG : SCTX_W_POS);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (item_ff.func == FUNC_FLUSH) begin
               state_in = run_open ? ST_SIG : ST_IDLE;
            end else if (run_open && !plane_bit) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ACC1;
            end
         end
         ST_ACC1: state_in = ST_ACC2;
         ST_ACC2: state_in = ST_CMPN;
         ST_CMPN: state_in = ST_CMPW;
         ST_CMPW: state_in = ST_SIG;
         ST_SIG: begin
            if (flush_ff) begin
               if (!run_beat.busy) begin
                  state_in = ST_IDLE;
               end
            end else if (!run_beat.busy && out_free) begin
               state_in = sign_needed ? ST_SIGN : ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      item_in      = item_ff;
      acc_in       = acc_ff;
      gtn_in       = gtn_ff;
      gtw_in       = gtw_ff;
      flush_in     = flush_ff;
      zero_run_in  = zero_run_ff;
      alu_a        = ALU_W'(vd);
      alu_b        = ALU_W'(par_m);
      alu_sub      = 1'b0;
      run_start    = 1'b0;
      run_adv      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
            end
         end
         ST_EVAL: begin
            flush_in = item_ff.func == FUNC_FLUSH;
            acc_in   = alu_res;
            if (item_ff.func == FUNC_FLUSH) begin
               if (run_open) begin
                  run_start   = 1'b1;
                  zero_run_in = '0;
               end
            end else if (run_open && !plane_bit) begin
               if (zero_run_ff < RUN_W'(BAND_PIXELS)) begin
                  zero_run_in = zero_run_ff + RUN_W'(1);
               end
            end else if (run_open) begin
               run_start   = 1'b1;
               zero_run_in = '0;
            end
         end
         ST_ACC1: begin
            alu_a  = acc_ff;
            alu_b  = ALU_W'(nn);
            acc_in = alu_res;
         end
         ST_ACC2: begin
            alu_a  = acc_ff;
            alu_b  = ALU_W'(w);
            acc_in = alu_res;
         end
         ST_CMPN: begin
            alu_b   = ALU_W'(nn);
            alu_sub = 1'b1;
            gtn_in  = alu_res[ALU_W-1];
         end
         ST_CMPW: begin
            alu_b   = ALU_W'(w);
            alu_sub = 1'b1;
            gtw_in  = alu_res[ALU_W-1];
         end
         default: begin
         end
      endcase

      if (run_beat.busy && out_free) begin
         run_adv                = 1'b1;
         rsp_valid_in           = 1'b1;
         rsp_in.coded_bit       = run_beat.coded_bit;
         rsp_in.model_class     = run_beat.model_class;
         rsp_in.context_index   = '0;
         rsp_in.last            = run_beat.final_beat && flush_ff;
      end else if ((state_ff == ST_SIG) && !flush_ff && out_free) begin
         rsp_valid_in           = 1'b1;
         rsp_in.coded_bit       = plane_bit;
         rsp_in.model_class     = CLS_SIG;
         rsp_in.context_index   = {gtw_ff, gtn_ff, val_ctx};
         rsp_in.last            = !sign_needed;
         if (!plane_bit) begin
            zero_run_in = RUN_W'(1);
         end
      end else if ((state_ff == ST_SIGN) && out_free) begin
         rsp_valid_in           = 1'b1;
         rsp_in.coded_bit       = item_ff.coefficient[COEF_BITS-1];
         rsp_in.model_class     = CLS_SIGN;
         rsp_in.context_index   = CTX_W'(sctx);
         rsp_in.last            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zero_run_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         flush_ff     <= 1'b0;
         bit_plane_ff <= '0;
         next_mask_ff <= '0;
      end else begin
         state_ff     <= state_in;
         zero_run_ff  <= zero_run_in;
         rsp_valid_ff <= rsp_valid_in;
         flush_ff     <= flush_in;
         if (csr_we && (csr_index == CSR_BIT_PLANE)) begin
            bit_plane_ff <= csr_wdata[PLANE_W-1:0];
         end
         if (csr_we && (csr_index == CSR_NEXT_MASK)) begin
            next_mask_ff <= csr_wdata;
         end
      end
      item_ff <= item_in;
      acc_ff  <= acc_in;
      gtn_ff  <= gtn_in;
      gtw_ff  <= gtw_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_run_not_idle: assert property (@(posedge clock) disable iff (reset)
      run_beat.busy |-> (state_ff != ST_IDLE))
      else $error("run beats pending while idle");

   a_run_sat: assert property (@(posedge clock) disable iff (reset)
      zero_run_ff <= RUN_W'(BAND_PIXELS))
      else $error("zero run beyond band size");

   a_sign_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.model_class == CLS_SIGN)) |-> rsp_ff.last)
      else $error("sign beat not last");

   a_run_last_flush: assert property (@(posedge clock) disable iff (reset)
      (run_adv && !flush_ff) |=> !rsp_ff.last)
      else $error("run beat marked last outside a flush");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL) && !run_beat.busy)
      else $error("accepted beat not evaluated");

endmodule

/* sim/bitplane_context_runlength_modeler_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bit-plane context / run-length modeler top level.
module bitplane_context_runlength_modeler_top_tb;
   import bcrm_pkg::*;

   localparam int RUN_LIMIT = BAND_PIXELS_DEF;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_RUN = 40;
   localparam logic [CTX_W-1:0] SHAPE_NORTH = 6'd16;
   localparam logic [CTX_W-1:0] SHAPE_WEST = 6'd32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_BIT_PLANE;
   logic [MASK_W-1:0] csr_wdata = '0;

   // predictor state, mirrors the block after reset
   logic [PLANE_W-1:0] plane_reg = '0;
   logic [MASK_W-1:0] mask_reg = '0;
   logic [16:0] open_run = '0;
   rsp_type expected_decisions[$];

   int mismatch_count = 0;
   bit idle_on = 1'b1;
   bit req_offered = 1'b0;
   int rsp_hold_cycles = 0;
   int rsp_stall = 0;

   bitplane_context_runlength_modeler_top dut (.*);

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [16:0] magnitude(logic [15:0] v);
      return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
   endfunction

   function automatic void add_decision(logic bitv, logic [2:0] cls, logic [CTX_W-1:0] ctx);
      rsp_type d;
      d.coded_bit = bitv;
      d.model_class = cls;
      d.context_index = ctx;
      d.last = 1'b0;
      expected_decisions.push_back(d);
   endfunction

   // zero flag, unary length of the count, then the count below its top bit
   function automatic void add_run(logic [16:0] len);
      int nbits;
      nbits = 0;
      if (len == 0) begin
         add_decision(1'b1, CLS_RZERO, '0);
      end else begin
         add_decision(1'b0, CLS_RZERO, '0);
         while ((len >> nbits) > 1) nbits++;
         for (int i = 0; i < nbits; i++) add_decision(1'b0, CLS_RUNARY, '0);
         add_decision(1'b1, CLS_RUNARY, '0);
         for (int i = nbits; i > 0; i--) add_decision(len[i-1], CLS_RBITS, '0);
      end
   endfunction

   function automatic void predict_decisions(req_type item);
      int start_count;
      logic [16:0] mag, done, vd, pm, nm, wm, known;
      logic [19:0] total;
      logic [CTX_W-1:0] ctx;
      logic [SCTX_W-1:0] sctx;
      logic bitv;
      rsp_type tail;
      start_count = expected_decisions.size();
      if (item.func == FUNC_FLUSH) begin
         if (open_run != 0) begin
            add_run(open_run - 17'd1);
            open_run = '0;
         end
      end else begin
         known = {2'b00, mask_reg};
         mag = magnitude(item.coefficient);
         done = known ^ (17'd1 << plane_reg);
         vd = mag & done;
         pm = magnitude(item.parent_coef) & known;
         sctx = '0;
         if (item.first_row) begin
            nm = vd;
         end else begin
            nm = magnitude(item.north_coef) & known;
            if (nm != 0) sctx += item.north_coef[15] ? SCTX_N_NEG : SCTX_N_POS;
         end
         if (item.first_col) begin
            wm = vd;
         end else begin
            wm = magnitude(item.west_coef) & known;
            if (wm != 0) sctx += item.west_coef[15] ? SCTX_W_NEG : SCTX_W_POS;
         end
         total = (20'(vd) + 20'(pm) + 20'(nm) + 20'(wm)) >> 2;
         ctx = (total > 20'(VAL_CTX_MAX)) ? CTX_W'(VAL_CTX_MAX) : total[CTX_W-1:0];
         if (nm > vd) ctx += SHAPE_NORTH;
         if (wm > vd) ctx += SHAPE_WEST;
         bitv = mag[plane_reg];
         if (open_run != 0 && !bitv) begin
            if (open_run < RUN_LIMIT) open_run++;
         end else begin
            if (open_run != 0) begin
               add_run(open_run - 17'd1);
               open_run = '0;
            end
            add_decision(bitv, CLS_SIG, ctx);
            if (!bitv) open_run = 17'd1;
            else if (vd == 0) add_decision(item.coefficient[15], CLS_SIGN, CTX_W'(sctx));
         end
      end
      if (expected_decisions.size() > start_count) begin
         tail = expected_decisions.pop_back();
         tail.last = 1'b1;
         expected_decisions.push_back(tail);
      end
   endfunction

   function automatic req_type coef_item(logic [15:0] c, logic [15:0] n, logic [15:0] w,
                                         logic [15:0] p, logic fr, logic fc);
      req_type item;
      item.func = FUNC_COEF;
      item.coefficient = c;
      item.north_coef = n;
      item.west_coef = w;
      item.parent_coef = p;
      item.first_row = fr;
      item.first_col = fc;
      return item;
   endfunction

   function automatic req_type flush_item();
      req_type item;
      item = coef_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom), 1'($urandom));
      item.func = FUNC_FLUSH;
      return item;
   endfunction

   function automatic logic [15:0] pick_coef(logic want_one);
      logic [16:0] mag;
      logic [15:0] raw;
      if ($urandom_range(0, 19) == 0) return 16'($urandom);
      case ($urandom_range(0, 2))
         0: mag = 17'($urandom_range(0, 15));
         1: mag = 17'($urandom_range(0, 1023));
         default: mag = 17'($urandom_range(0, 32767));
      endcase
      if (plane_reg == 4'd15) begin
         if (want_one) return 16'h8000;
      end else begin
         mag[plane_reg] = want_one;
      end
      raw = mag[15:0];
      return $urandom_range(0, 1) ? -raw : raw;
   endfunction

   function automatic logic [15:0] pick_neighbor();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = 16'h8000;
         2, 3: v = 16'($urandom_range(0, 63));
         default: v = 16'($urandom);
      endcase
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic req_type random_item(logic want_one);
      return coef_item(pick_coef(want_one), pick_neighbor(), pick_neighbor(), pick_neighbor(),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
   endfunction

   task automatic send_beat(req_type item);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         if (req_offered) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      req_offered = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_decisions(item);
   endtask

   task automatic release_req();
      if (req_offered) req_valid <= 1'b0;
      req_offered = 1'b0;
   endtask

   task automatic wait_drain();
      release_req();
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [MASK_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BIT_PLANE) plane_reg = value[PLANE_W-1:0];
      else mask_reg = value;
   endtask

   task automatic set_config(logic [PLANE_W-1:0] plane, logic [MASK_W-1:0] mask);
      wait_drain();
      write_csr(CSR_BIT_PLANE, MASK_W'(plane));
      write_csr(CSR_NEXT_MASK, mask);
   endtask

   // reset settings, then plane 3 with bits 4 to 14 known
   task automatic test_directed();
      send_beat(flush_item());
      send_beat(coef_item(16'd1, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
      send_beat(coef_item(16'd2, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
      set_config(4'd3, 15'h7FF8);
      send_beat(coef_item(16'd8, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
      send_beat(coef_item(-16'sd8, -16'sd16, 16'd24, 16'd0, 1'b0, 1'b0));
      send_beat(coef_item(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
      send_beat(coef_item(16'd16, 16'd8, 16'd8, 16'd8, 1'b0, 1'b0));
      send_beat(coef_item(-16'sd4, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
      send_beat(coef_item(16'd32767, 16'd5, -16'sd5, 16'd100, 1'b0, 1'b0));
      send_beat(coef_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0));
      send_beat(flush_item());
      send_beat(flush_item());
      send_beat(coef_item(16'd8, 16'd0, -16'sd40, 16'd0, 1'b1, 1'b0));
      send_beat(coef_item(-16'sd9, 16'd32767, 16'd0, 16'h8000, 1'b0, 1'b1));
      send_beat(coef_item(16'd0, 16'd32767, 16'd32767, 16'd32767, 1'b0, 1'b0));
      send_beat(flush_item());
   endtask

   // top plane, magnitude bit 15, and a mask missing the plane bit
   task automatic test_plane_extremes();
      set_config(4'd15, 15'h7FFF);
      send_beat(coef_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0));
      send_beat(coef_item(16'd32767, 16'd1, 16'd1, 16'd1, 1'b0, 1'b0));
      send_beat(coef_item(16'h8000, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
      set_config(4'd14, 15'h4000);
      send_beat(coef_item(-16'sd16384, 16'd16384, -16'sd16384, 16'd0, 1'b0, 1'b0));
      send_beat(coef_item(16'd16383, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
      send_beat(flush_item());
      set_config(4'd0, 15'h7FFF);
      send_beat(coef_item(-16'sd1, -16'sd1, 16'd1, -16'sd1, 1'b0, 1'b0));
      send_beat(coef_item(16'd2, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
      send_beat(flush_item());
   endtask

   // receiver holds off while the sender keeps offering, then sender waits for drain
   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 10; i++) send_beat(random_item(i[0]));
      wait_drain();
      idle_on = 1'b1;
      for (int i = 0; i < 6; i++) send_beat(random_item(1'($urandom_range(0, 1))));
   endtask

   task automatic test_random();
      logic [PLANE_W-1:0] pl;
      int sent;
      int zero_burst;
      zero_burst = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_config(4'd0, 15'h7FFF);
            1: set_config(4'd14, 15'h4000);
            2: begin
               pl = PLANE_W'($urandom_range(1, 13));
               set_config(pl, 15'h7FFF << pl);
            end
            3: set_config(4'd15, 15'h7FFF);
            default: set_config(PLANE_W'($urandom_range(0, 15)), MASK_W'($urandom));
         endcase
         idle_on = (phase != 2);
         sent = 0;
         while (sent < 15) begin
            if ($urandom_range(0, 11) == 0) begin
               send_beat(flush_item());
            end else if (zero_burst != 0) begin
               send_beat(random_item(1'b0));
               zero_burst--;
            end else begin
               if ($urandom_range(0, 7) == 0) zero_burst = $urandom_range(2, 24);
               send_beat(random_item(1'($urandom_range(0, 1))));
            end
            sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   // long zero run with a multi-bit count, closed by a new significant one
   task automatic test_long_run();
      set_config(4'd0, 15'h0001);
      idle_on = 1'b0;
      for (int i = 0; i < LONG_RUN; i++) send_beat(random_item(1'b0));
      send_beat(random_item(1'b1));
      send_beat(flush_item());
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_decisions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: bit %0d class %0d ctx %0d last %0d",
                        rsp_data.coded_bit, rsp_data.model_class,
                        rsp_data.context_index, rsp_data.last);
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_data.coded_bit !== want.coded_bit ||
                rsp_data.model_class !== want.model_class ||
                rsp_data.context_index !== want.context_index ||
                rsp_data.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch bit/class/ctx/last: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           want.coded_bit, want.model_class, want.context_index, want.last,
                           rsp_data.coded_bit, rsp_data.model_class,
                           rsp_data.context_index, rsp_data.last);
            end
         end
      end
      if (rsp_hold_cycles != 0) begin
         rsp_stall = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end
      if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_plane_extremes();
      test_backpressure();
      test_random();
      test_long_run();
      release_req();
      for (int i = 0; i < 20000 && expected_decisions.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_decisions.size() != 0) begin
         $display("%0d expected beats never arrived", expected_decisions.size());
         mismatch_count += expected_decisions.size();
      end
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
